FILE: rtl/rgbhsl_pkg.sv
// Shared constants for the RGB to HSL converter.
// No dependencies; used by every module of the converter.
package rgbhsl_pkg;

    // Default channel and hue widths of the top level.
    localparam int DEF_CHANNEL_BITS = 8;
    localparam int DEF_HUE_BITS     = 16;

    // Saturation is a 16-bit fraction where all ones means 1.0.
    localparam int SAT_BITS = 16;

    // Depth of the queue between the classifier and the divider pipeline.
    localparam int QUEUE_DEPTH = 4;

endpackage

FILE: rtl/rgbhsl_front.sv
// Classifier of the RGB to HSL converter: max, min, sector and the
// operands of both divisions. Depends on rgbhsl_pkg.
module rgbhsl_front
    import rgbhsl_pkg::*;
#(
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
    input  logic [CHANNEL_BITS-1:0]          red,
    input  logic [CHANNEL_BITS-1:0]          green,
    input  logic [CHANNEL_BITS-1:0]          blue,
    output logic [CHANNEL_BITS+2:0]          hue_num,
    output logic [CHANNEL_BITS+2:0]          hue_div,
    output logic [CHANNEL_BITS+SAT_BITS-1:0] sat_num,
    output logic [CHANNEL_BITS-1:0]          sat_div,
    output logic [CHANNEL_BITS:0]            sum,
    output logic                             grey
);

    localparam int CB = CHANNEL_BITS;
    localparam int HW = CHANNEL_BITS + 3;
    localparam int NW = CHANNEL_BITS + SAT_BITS;

    localparam logic [1:0] SECTOR_RED   = 2'd0;
    localparam logic [1:0] SECTOR_GREEN = 2'd1;
    localparam logic [1:0] SECTOR_BLUE  = 2'd2;

    localparam logic [CB:0] FULL2 = {1'b1, {(CB-1){1'b1}}, 1'b0};
    localparam logic [CB:0] FULL  = {1'b0, {CB{1'b1}}};

    logic [1:0]    sector;
    logic [CB-1:0] mx;
    logic [CB-1:0] mn;
    logic [CB-1:0] chroma;
    logic [HW-1:0] c1;
    logic [HW-1:0] c2;
    logic [HW-1:0] c4;
    logic [HW-1:0] c6;
    logic [CB:0]   denom_wide;

    always_comb
    begin
        // Largest channel; ties go to red, then green, then blue.
        if (red >= green && red >= blue)
        begin
            sector = SECTOR_RED;
            mx     = red;
        end
        else if (green >= blue)
        begin
            sector = SECTOR_GREEN;
            mx     = green;
        end
        else
        begin
            sector = SECTOR_BLUE;
            mx     = blue;
        end

        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end

        chroma = mx - mn;
        sum    = {1'b0, mx} + {1'b0, mn};
        grey   = (chroma == '0);

        c1 = HW'(chroma);
        c2 = c1 << 1;
        c4 = c1 << 2;
        c6 = c4 + c2;

        // Hue numerator 2*sector*C + diff (plus 6C when diff < 0), kept in [0, 6C).
        case (sector)
            SECTOR_RED:
            begin
                if (green >= blue)
                begin
                    hue_num = HW'(green) - HW'(blue);
                end
                else
                begin
                    hue_num = c6 - (HW'(blue) - HW'(green));
                end
            end
            SECTOR_GREEN:
            begin
                hue_num = c2 + HW'(blue) - HW'(red);
            end
            SECTOR_BLUE:
            begin
                hue_num = c4 + HW'(red) - HW'(green);
            end
            default:
            begin
                hue_num = '0;
            end
        endcase
        hue_div = c6;

        // Saturation: 65535*C over min(sum, 2*FULL - sum).
        sat_num    = {chroma, {SAT_BITS{1'b0}}} - NW'(chroma);
        denom_wide = (sum > FULL) ? (FULL2 - sum) : sum;
        sat_div    = denom_wide[CB-1:0];
    end

endmodule

FILE: rtl/rgbhsl_queue.sv
// Small register queue between the classifier and the divider pipeline.
// Depends on rgbhsl_pkg for its default depth.
module rgbhsl_queue
    import rgbhsl_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] entry_reg [0:DEPTH-1];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == COUNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/rgbhsl_back.sv
// Divider pipeline of the RGB to HSL converter: one quotient bit of hue
// and of saturation per stage. Depends on rgbhsl_pkg.
module rgbhsl_back
    import rgbhsl_pkg::*;
#(
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
    parameter int HUE_BITS     = DEF_HUE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [CHANNEL_BITS+2:0]          hue_num,
    input  logic [CHANNEL_BITS+2:0]          hue_div,
    input  logic [CHANNEL_BITS+SAT_BITS-1:0] sat_num,
    input  logic [CHANNEL_BITS-1:0]          sat_div,
    input  logic [CHANNEL_BITS:0]            sum,
    input  logic                             grey,
    output logic                             done,
    output logic [HUE_BITS-1:0]              hue,
    output logic [SAT_BITS-1:0]              saturation,
    output logic [CHANNEL_BITS:0]            lightness_doubled,
    output logic                             hue_undefined
);

    localparam int CB     = CHANNEL_BITS;
    localparam int HW     = CHANNEL_BITS + 3;
    localparam int STAGES = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;

    logic                valid_reg [0:STAGES];
    logic [HW-1:0]       hrem_reg  [0:STAGES];
    logic [HW-1:0]       hdiv_reg  [0:STAGES];
    logic [HUE_BITS-1:0] hq_reg    [0:STAGES];
    logic [CB-1:0]       srem_reg  [0:STAGES];
    logic [CB-1:0]       sdiv_reg  [0:STAGES];
    logic [SAT_BITS-1:0] slow_reg  [0:STAGES];
    logic [SAT_BITS-1:0] sq_reg    [0:STAGES];
    logic [CB:0]         sum_reg   [0:STAGES];
    logic                grey_reg  [0:STAGES];

    logic                done_reg;
    logic [HUE_BITS-1:0] hue_reg;
    logic [SAT_BITS-1:0] sat_reg;
    logic [CB:0]         light_reg;
    logic                undef_reg;

    // Stage 0 holds the operands. The upper part of each dividend is the
    // starting remainder, already below its divisor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hrem_reg[0] <= hue_num;
        hdiv_reg[0] <= hue_div;
        hq_reg[0]   <= '0;
        srem_reg[0] <= sat_num[CB+SAT_BITS-1:SAT_BITS];
        sdiv_reg[0] <= sat_div;
        slow_reg[0] <= sat_num[SAT_BITS-1:0];
        sq_reg[0]   <= '0;
        sum_reg[0]  <= sum;
        grey_reg[0] <= grey;
    end

    for (genvar k = 1; k <= STAGES; k++)
    begin : g_stage
        logic [HW:0]         htrial;
        logic [HW-1:0]       hrem_next;
        logic [HUE_BITS-1:0] hq_next;
        logic [CB:0]         strial;
        logic [CB-1:0]       srem_next;
        logic [SAT_BITS-1:0] sq_next;
        logic [SAT_BITS-1:0] slow_next;

        always_comb
        begin
            htrial    = {hrem_reg[k-1], 1'b0};
            hrem_next = hrem_reg[k-1];
            hq_next   = hq_reg[k-1];
            if (k <= HUE_BITS)
            begin
                if (htrial >= {1'b0, hdiv_reg[k-1]})
                begin
                    hrem_next = HW'(htrial - {1'b0, hdiv_reg[k-1]});
                    hq_next   = {hq_reg[k-1][HUE_BITS-2:0], 1'b1};
                end
                else
                begin
                    hrem_next = htrial[HW-1:0];
                    hq_next   = {hq_reg[k-1][HUE_BITS-2:0], 1'b0};
                end
            end

            strial    = {srem_reg[k-1], slow_reg[k-1][SAT_BITS-1]};
            srem_next = srem_reg[k-1];
            sq_next   = sq_reg[k-1];
            slow_next = slow_reg[k-1];
            if (k <= SAT_BITS)
            begin
                slow_next = slow_reg[k-1] << 1;
                if (strial >= {1'b0, sdiv_reg[k-1]})
                begin
                    srem_next = CB'(strial - {1'b0, sdiv_reg[k-1]});
                    sq_next   = {sq_reg[k-1][SAT_BITS-2:0], 1'b1};
                end
                else
                begin
                    srem_next = strial[CB-1:0];
                    sq_next   = {sq_reg[k-1][SAT_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            hrem_reg[k] <= hrem_next;
            hdiv_reg[k] <= hdiv_reg[k-1];
            hq_reg[k]   <= hq_next;
            srem_reg[k] <= srem_next;
            sdiv_reg[k] <= sdiv_reg[k-1];
            slow_reg[k] <= slow_next;
            sq_reg[k]   <= sq_next;
            sum_reg[k]  <= sum_reg[k-1];
            grey_reg[k] <= grey_reg[k-1];
        end
    end

    // Grey pixels have a zero hue divisor; their quotients are replaced here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg   <= grey_reg[STAGES] ? '0 : hq_reg[STAGES];
        sat_reg   <= grey_reg[STAGES] ? '0 : sq_reg[STAGES];
        light_reg <= sum_reg[STAGES];
        undef_reg <= grey_reg[STAGES];
    end

    assign done              = done_reg;
    assign hue               = hue_reg;
    assign saturation        = sat_reg;
    assign lightness_doubled = light_reg;
    assign hue_undefined     = undef_reg;

endmodule

FILE: rtl/rgb_to_hsl_converter.sv
// RGB to HSL converter, one pixel per clock.
// A pixel is taken on start when busy is low; the result appears on the
// result ports for one cycle, marked by done. There is no other port.
//
// The classifier finds the largest and smallest channel (ties to red,
// then green, then blue), the chroma and the operands of two divisions,
// and writes them into a short queue. The divider pipeline pops one item
// per cycle while the queue holds one, and computes hue and saturation with
// one quotient bit per stage, max(HUE_BITS, 16) stages in all.
// An accepted item passes through the queue, stage 0, the quotient stages
// and the output register; a new item may be accepted every cycle that busy
// is low, and the divider pipeline sets that rate.
// Since the pipeline never stalls, the queue holds at most one item and
// busy stays low in operation. done has no back pressure: the receiver
// must take each result in the cycle it is shown.
// Reset empties the queue and clears every valid bit; no result is
// shown until an item has been accepted after reset.
// A grey pixel (all channels equal) gives hue 0, saturation 0 and sets
// hue_undefined; lightness_doubled is max + min in every case.
module rgb_to_hsl_converter
    import rgbhsl_pkg::*;
#(
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
    parameter int HUE_BITS     = DEF_HUE_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [CHANNEL_BITS-1:0] red,
    input  logic [CHANNEL_BITS-1:0] green,
    input  logic [CHANNEL_BITS-1:0] blue,
    output logic                    done,
    output logic [HUE_BITS-1:0]     hue,
    output logic [SAT_BITS-1:0]     saturation,
    output logic [CHANNEL_BITS:0]   lightness_doubled,
    output logic                    hue_undefined
);

    localparam int CB = CHANNEL_BITS;
    localparam int HW = CHANNEL_BITS + 3;
    localparam int NW = CHANNEL_BITS + SAT_BITS;
    localparam int LW = CHANNEL_BITS + 1;
    localparam int QW = HW + HW + NW + CB + LW + 1;
    localparam int LATENCY = ((HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS) + 3;

    logic [HW-1:0] f_hue_num;
    logic [HW-1:0] f_hue_div;
    logic [NW-1:0] f_sat_num;
    logic [CB-1:0] f_sat_div;
    logic [LW-1:0] f_sum;
    logic          f_grey;

    logic [HW-1:0] b_hue_num;
    logic [HW-1:0] b_hue_div;
    logic [NW-1:0] b_sat_num;
    logic [CB-1:0] b_sat_div;
    logic [LW-1:0] b_sum;
    logic          b_grey;

    logic [QW-1:0] q_push_data;
    logic [QW-1:0] q_pop_data;
    logic          q_full;
    logic          q_empty;
    logic          accept;

    assign busy   = q_full;
    assign accept = start && !q_full;

    rgbhsl_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .red     (red),
        .green   (green),
        .blue    (blue),
        .hue_num (f_hue_num),
        .hue_div (f_hue_div),
        .sat_num (f_sat_num),
        .sat_div (f_sat_div),
        .sum     (f_sum),
        .grey    (f_grey)
    );

    assign q_push_data = {f_hue_num, f_hue_div, f_sat_num, f_sat_div, f_sum, f_grey};

    rgbhsl_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (q_push_data),
        .pop       (!q_empty),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign {b_hue_num, b_hue_div, b_sat_num, b_sat_div, b_sum, b_grey} = q_pop_data;

    // The divider pipeline takes an item in every cycle that the queue
    // has one, so it drains the queue as fast as it is filled.
    rgbhsl_back #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .HUE_BITS     (HUE_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (!q_empty),
        .hue_num           (b_hue_num),
        .hue_div           (b_hue_div),
        .sat_num           (b_sat_num),
        .sat_div           (b_sat_div),
        .sum               (b_sum),
        .grey              (b_grey),
        .done              (done),
        .hue               (hue),
        .saturation        (saturation),
        .lightness_doubled (lightness_doubled),
        .hue_undefined     (hue_undefined)
    );

`ifndef NO_ASSERTIONS
    // Every accepted item comes out with done, after the delay LATENCY.
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted item produced no result");

    // No result appears without an item accepted LATENCY earlier.
    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching item");

    // A grey pixel reports zero hue and saturation; a colored one has a
    // nonzero saturation.
    a_grey_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hue_undefined ? (hue == '0 && saturation == '0)
                                : (saturation != '0)))
        else $error("hue or saturation inconsistent with grey flag");

    // The pipeline drains the queue every cycle, so it never fills.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("queue filled up");
`endif

endmodule
